// ----- rtl/core/dqr_pkg.sv -----
`default_nettype none

package dqr_pkg;

  localparam int DQR_DEPTH      = 16;
  localparam int DQR_DATA_WIDTH = 32;

  // command codes carried by the input word
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_LIST       = 3'd4,
    CMD_REPLACE    = 3'd5
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/dqr_in_if.sv -----
`default_nettype none

interface dqr_in_if import dqr_pkg::*; #(
  parameter int DATA_WIDTH = DQR_DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   command;
  logic signed [DATA_WIDTH-1:0] value;
  logic signed [DATA_WIDTH-1:0] new_value;

  modport source (output valid, output command, output value, output new_value,
                  input ready);
  modport sink   (input valid, input command, input value, input new_value,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dqr_out_if.sv -----
`default_nettype none

interface dqr_out_if import dqr_pkg::*; #(
  parameter int DATA_WIDTH  = DQR_DATA_WIDTH,
  parameter int COUNT_WIDTH = $clog2(DQR_DEPTH + 1)
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic signed [DATA_WIDTH-1:0] data;
  logic [COUNT_WIDTH-1:0]       count;
  logic                         last;

  modport source (output valid, output status, output data, output count,
                  output last, input ready);
  modport sink   (input valid, input status, input data, input count,
                  input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/deque_with_replace_unit.sv -----
`default_nettype none

// double-ended queue of up to DEPTH signed words held in a ring memory
// in_ch carries one command word (command, value, new_value); out_ch carries
// result words (status, data, count, last), both valid/ready handshakes
// push front/back, pop front/back and replace give one result word with last set
// list gives one word per held element, front to back, last on the final one;
// an empty list gives a single empty-status word
// sequencing: a command is taken only while the controller is idle
//   push, unused codes and any flagged no-op: result registered, then loaded
//   into the output register; pop: the same after the synchronous memory read
//   list: one word per cycle streamed from the memory read port while the
//   output register is free
//   replace: one element compared per cycle on the read port, the match
//   written back through the write port
// the output register lets a new command be taken while the last result word
// still waits; when the receiver stalls, a list or a pending result simply
// holds and the memory read data is kept until the word is taken
// reset (synchronous, active low) empties the queue and drops any pending word;
// the element memory itself is not cleared and needs no clearing pass
module deque_with_replace_unit import dqr_pkg::*; #(
  parameter int DEPTH      = DQR_DEPTH,
  parameter int DATA_WIDTH = DQR_DATA_WIDTH
) (
  input wire logic clk,
  input wire logic rst_n,
  dqr_in_if.sink   in_ch,
  dqr_out_if.source out_ch
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_LIST,
    S_SCAN,
    S_RESP
  } state_t;

  // ring arithmetic, sum stays below twice the depth
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] next_slot(logic [AW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] prev_slot(logic [AW-1:0] p);
    return (p == '0) ? LAST_SLOT : p - AW'(1);
  endfunction

  // control state
  state_t        state_r, state_nxt;
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;     // slot whose word sits on the read port
  logic [CW-1:0] idx_r, idx_nxt;     // offset of that slot from the front

  // command operands and the pending single result
  logic signed [DATA_WIDTH-1:0] val_r, val_nxt;
  logic signed [DATA_WIDTH-1:0] nval_r, nval_nxt;
  status_t                      res_status_r, res_status_nxt;
  logic signed [DATA_WIDTH-1:0] res_data_r, res_data_nxt;

  // output register
  logic                         out_valid_r;
  status_t                      out_status_r;
  logic signed [DATA_WIDTH-1:0] out_data_r;
  logic [CW-1:0]                out_count_r;
  logic                         out_last_r;

  logic                         load_out;
  status_t                      ld_status;
  logic signed [DATA_WIDTH-1:0] ld_data;
  logic                         ld_last;
  logic                         out_free;
  logic                         last_elem;

  // memory port
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic signed [DATA_WIDTH-1:0] mem_wdata;
  logic                         mem_re;
  logic [AW-1:0]                mem_raddr;
  logic signed [DATA_WIDTH-1:0] mem_rdata;

  dqr_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign last_elem   = (idx_r + CW'(1)) == occ_r;
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    occ_nxt        = occ_r;
    ptr_nxt        = ptr_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    nval_nxt       = nval_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    load_out       = 1'b0;
    ld_status      = res_status_r;
    ld_data        = res_data_r;
    ld_last        = 1'b1;
    mem_we         = 1'b0;
    mem_waddr      = ptr_r;
    mem_wdata      = in_ch.value;
    mem_re         = 1'b0;
    mem_raddr      = ptr_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          res_status_nxt = ST_OK;
          res_data_nxt   = '0;
          state_nxt      = S_RESP;
          case (in_ch.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              if (occ_r == FULL_COUNT) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we = 1'b1;
                if (in_ch.command == CMD_PUSH_FRONT) begin
                  mem_waddr = prev_slot(front_r);
                  front_nxt = prev_slot(front_r);
                end else begin
                  mem_waddr = wrap_add(front_r, occ_r);
                end
                occ_nxt = occ_r + CW'(1);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (occ_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                mem_re = 1'b1;
                if (in_ch.command == CMD_POP_FRONT) begin
                  mem_raddr = front_r;
                  front_nxt = next_slot(front_r);
                end else begin
                  mem_raddr = wrap_add(front_r, occ_r - CW'(1));
                end
                occ_nxt   = occ_r - CW'(1);
                state_nxt = S_POP;
              end
            end
            CMD_LIST: begin
              if (occ_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_r;
                ptr_nxt   = front_r;
                idx_nxt   = '0;
                state_nxt = S_LIST;
              end
            end
            CMD_REPLACE: begin
              if (occ_r == '0) begin
                res_status_nxt = ST_NOT_FOUND;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_r;
                ptr_nxt   = front_r;
                idx_nxt   = '0;
                val_nxt   = in_ch.value;
                nval_nxt  = in_ch.new_value;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end

      S_POP: begin
        res_status_nxt = ST_OK;
        res_data_nxt   = mem_rdata;
        state_nxt      = S_RESP;
      end

      // stream one element per cycle while the output is free, next read issued as the word is loaded
      S_LIST: begin
        if (out_free) begin
          load_out  = 1'b1;
          ld_status = ST_OK;
          ld_data   = mem_rdata;
          ld_last   = last_elem;
          if (last_elem) begin
            state_nxt = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = next_slot(ptr_r);
            ptr_nxt   = next_slot(ptr_r);
            idx_nxt   = idx_r + CW'(1);
          end
        end
      end

      // compare the word on the read port, fetch the next one meanwhile
      S_SCAN: begin
        if (mem_rdata == val_r) begin
          mem_we         = 1'b1;
          mem_waddr      = ptr_r;
          mem_wdata      = nval_r;
          res_status_nxt = ST_OK;
          res_data_nxt   = mem_rdata;
          state_nxt      = S_RESP;
        end else if (last_elem) begin
          res_status_nxt = ST_NOT_FOUND;
          res_data_nxt   = '0;
          state_nxt      = S_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = next_slot(ptr_r);
          ptr_nxt   = next_slot(ptr_r);
          idx_nxt   = idx_r + CW'(1);
        end
      end

      S_RESP: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      front_r      <= front_nxt;
      occ_r        <= occ_nxt;
      ptr_r        <= ptr_nxt;
      idx_r        <= idx_nxt;
      val_r        <= val_nxt;
      nval_r       <= nval_nxt;
      res_status_r <= res_status_nxt;
      res_data_r   <= res_data_nxt;
      if (load_out) begin
        out_valid_r  <= 1'b1;
        out_status_r <= ld_status;
        out_data_r   <= ld_data;
        out_count_r  <= occ_r;
        out_last_r   <= ld_last;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.data   = out_data_r;
  assign out_ch.count  = out_count_r;
  assign out_ch.last   = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/core/dqr_store.sv -----
`default_nettype none

module dqr_store import dqr_pkg::*; #(
  parameter int DEPTH      = DQR_DEPTH,
  parameter int DATA_WIDTH = DQR_DATA_WIDTH,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [AW-1:0]                wr_addr,
  input  wire logic signed [DATA_WIDTH-1:0] wr_data,
  input  wire logic                         rd_en,
  input  wire logic [AW-1:0]                rd_addr,
  output      logic signed [DATA_WIDTH-1:0] rd_data
);

  logic signed [DATA_WIDTH-1:0] mem_r [DEPTH];
  logic signed [DATA_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- test/deque_with_replace_unit_test.sv -----
module deque_with_replace_unit_test;
  import dqr_pkg::*;

  localparam int CNT_W        = $clog2(DQR_DEPTH + 1);
  localparam int MAX_GAP      = 6;
  localparam int STALL_LIMIT  = 1000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES = 40;    // longer than a full list or replace walk
  localparam int RANDOM_ITEMS = 150;

  // the two command codes the block answers without doing anything
  localparam logic [2:0] CMD_RSVD_LO = 3'd6;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;

  typedef logic signed [DQR_DATA_WIDTH-1:0] word_t;

  localparam word_t WORD_MIN = {1'b1, {(DQR_DATA_WIDTH-1){1'b0}}};
  localparam word_t WORD_MAX = ~WORD_MIN;

  typedef struct {
    status_t          st;
    word_t            data;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } result_word_t;

  // one row of the directed table; rep > 1 pushes val, val+1, ...
  // typed rows carry their single result word written out by hand
  typedef struct {
    logic [2:0]       cmd;
    word_t            val;
    word_t            nval;
    int               rep;
    bit               typed;
    status_t          st;
    word_t            data;
    logic [CNT_W-1:0] cnt;
  } stim_row_t;

  logic clk;
  logic rst_n;

  dqr_in_if  in_bus ();
  dqr_out_if out_bus ();

  deque_with_replace_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // shadow copy of the deque: ring memory, front slot and fill level
  word_t ring_store [DQR_DEPTH];
  int    ring_head;
  int    ring_fill;

  result_word_t expected_words [$];
  stim_row_t    directed_rows [$];

  int mismatch_count;
  int quiet_cycles;
  bit no_idle;

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int ring_slot(input int offset);
    return (ring_head + offset) % DQR_DEPTH;
  endfunction

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // advance the shadow deque by one command; when keep is set, queue the
  // result words it must produce, front to back
  task automatic apply_command(input logic [2:0] cmd, input word_t v, input word_t nv,
                               input bit keep);
    int    slot;
    bit    hit;
    word_t old;
    hit = 1'b0;
    old = '0;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (ring_fill >= DQR_DEPTH) begin
          // full: flagged no-op
          if (keep) expected_words.push_back('{ST_FULL, '0, CNT_W'(ring_fill), 1'b1});
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            ring_head = (ring_head + DQR_DEPTH - 1) % DQR_DEPTH;
            ring_store[ring_head] = v;
          end else begin
            ring_store[ring_slot(ring_fill)] = v;
          end
          ring_fill++;
          if (keep) expected_words.push_back('{ST_OK, '0, CNT_W'(ring_fill), 1'b1});
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (ring_fill == 0) begin
          if (keep) expected_words.push_back('{ST_EMPTY, '0, CNT_W'(0), 1'b1});
        end else begin
          if (cmd == CMD_POP_FRONT) begin
            old = ring_store[ring_head];
            ring_head = ring_slot(1);
          end else begin
            old = ring_store[ring_slot(ring_fill - 1)];
          end
          ring_fill--;
          if (keep) expected_words.push_back('{ST_OK, old, CNT_W'(ring_fill), 1'b1});
        end
      end
      CMD_LIST: begin
        if (ring_fill == 0) begin
          if (keep) expected_words.push_back('{ST_EMPTY, '0, CNT_W'(0), 1'b1});
        end else if (keep) begin
          for (int i = 0; i < ring_fill; i++)
            expected_words.push_back('{ST_OK, ring_store[ring_slot(i)], CNT_W'(ring_fill),
                                       (i == ring_fill - 1)});
        end
      end
      CMD_REPLACE: begin
        // first match counted from the front wins
        for (int i = 0; i < ring_fill && !hit; i++) begin
          slot = ring_slot(i);
          if (ring_store[slot] === v) begin
            old = ring_store[slot];
            ring_store[slot] = nv;
            hit = 1'b1;
          end
        end
        if (keep) begin
          if (hit) expected_words.push_back('{ST_OK, old, CNT_W'(ring_fill), 1'b1});
          else     expected_words.push_back('{ST_NOT_FOUND, '0, CNT_W'(ring_fill), 1'b1});
        end
      end
      default: begin
        // spare codes: answered, state untouched
        if (keep) expected_words.push_back('{ST_OK, '0, CNT_W'(ring_fill), 1'b1});
      end
    endcase
  endtask

  // drive one command word at the falling edge, hold it until taken
  task automatic send_cmd(input logic [2:0] cmd, input word_t v, input word_t nv,
                          input bit keep);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.command   <= cmd;
    in_bus.value     <= v;
    in_bus.new_value <= nv;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    apply_command(cmd, v, nv, keep);
  endtask

  // small values repeat often so replace finds duplicates and first-match matters
  function automatic word_t pick_value();
    case ($urandom_range(0, 3))
      0: return word_t'($urandom_range(0, 3));
      1: begin
        case ($urandom_range(0, 3))
          0:       return WORD_MIN;
          1:       return WORD_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return word_t'($urandom());
    endcase
  endfunction

  // search word for replace: mostly one that is held right now
  function automatic word_t pick_target();
    if (ring_fill > 0 && $urandom_range(0, 9) < 7)
      return ring_store[ring_slot($urandom_range(0, ring_fill - 1))];
    return pick_value();
  endfunction

  function automatic logic [2:0] choose_command(input bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 30)      return CMD_PUSH_BACK;
      else if (r < 55) return CMD_PUSH_FRONT;
      else if (r < 63) return CMD_POP_FRONT;
      else if (r < 71) return CMD_POP_BACK;
      else if (r < 78) return CMD_LIST;
      else if (r < 95) return CMD_REPLACE;
    end else begin
      if (r < 10)      return CMD_PUSH_BACK;
      else if (r < 20) return CMD_PUSH_FRONT;
      else if (r < 50) return CMD_POP_FRONT;
      else if (r < 80) return CMD_POP_BACK;
      else if (r < 87) return CMD_LIST;
      else if (r < 97) return CMD_REPLACE;
    end
    return ($urandom_range(0, 1) != 0) ? CMD_RSVD_HI : CMD_RSVD_LO;
  endfunction

  // result side: random stall before each word, then ready until one is taken
  initial begin : result_side
    int gap;
    out_bus.ready = 1'b0;
    forever begin
      gap = draw_gap();
      @(negedge clk);
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
    end
  end

  // compare every taken result word with the oldest expectation
  always @(posedge clk) begin : result_check
    result_word_t exp_word;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word status %0d data %h count %0d last %0b", $time,
                 out_bus.status, out_bus.data, out_bus.count, out_bus.last);
        mismatch_count++;
      end else begin
        exp_word = expected_words.pop_front();
        if (exp_word.st !== out_bus.status || exp_word.data !== out_bus.data ||
            exp_word.cnt !== out_bus.count || exp_word.last !== out_bus.last) begin
          $display("%0t: expected status %0d data %h count %0d last %0b", $time,
                   exp_word.st, exp_word.data, exp_word.cnt, exp_word.last);
          $display("%0t: actual   status %0d data %h count %0d last %0b", $time,
                   out_bus.status, out_bus.data, out_bus.count, out_bus.last);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: too long with no word moving on either channel
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
          (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[deque_with_replace_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [2:0] cmd;
    word_t      v;
    bit         filling;
    stim_row_t  row;

    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.command   = CMD_PUSH_FRONT;
    in_bus.value     = '0;
    in_bus.new_value = '0;
    no_idle          = 1'b0;
    mismatch_count   = 0;
    quiet_cycles     = 0;
    ring_head        = 0;
    ring_fill        = 0;
    filling          = 1'b1;
    foreach (ring_store[i]) ring_store[i] = '0;

    // directed table: empty-list corner cases first, then fill to the brim
    //                          cmd             val            nval      rep typed
    directed_rows.push_back('{CMD_LIST,       '0,            '0,        1, 1, ST_EMPTY,     '0, 0});
    directed_rows.push_back('{CMD_POP_FRONT,  '0,            '0,        1, 1, ST_EMPTY,     '0, 0});
    directed_rows.push_back('{CMD_POP_BACK,   '0,            '0,        1, 1, ST_EMPTY,     '0, 0});
    directed_rows.push_back('{CMD_REPLACE,    '0,            WORD_MAX,  1, 1, ST_NOT_FOUND, '0, 0});
    // push front from empty wraps the front slot below zero
    directed_rows.push_back('{CMD_PUSH_FRONT, WORD_MIN,      '0,        1, 1, ST_OK,        '0, 1});
    // pop back of a single element empties the list
    directed_rows.push_back('{CMD_POP_BACK,   '0,            '0,        1, 1, ST_OK,  WORD_MIN, 0});
    directed_rows.push_back('{CMD_RSVD_LO,    WORD_MAX,      WORD_MIN,  1, 1, ST_OK,        '0, 0});
    // sixteen pushes run across the max and min words
    directed_rows.push_back('{CMD_PUSH_BACK,  WORD_MAX - 7,  '0,       16, 0, ST_OK,        '0, 0});
    directed_rows.push_back('{CMD_PUSH_FRONT, '1,            '0,        1, 1, ST_FULL,      '0, 16});
    directed_rows.push_back('{CMD_PUSH_BACK,  '0,            '0,        1, 1, ST_FULL,      '0, 16});
    directed_rows.push_back('{CMD_LIST,       '0,            '0,        1, 0, ST_OK,        '0, 0});
    // match sits at the very back
    directed_rows.push_back('{CMD_REPLACE,    WORD_MIN + 7,  '1,        1, 0, ST_OK,        '0, 0});
    directed_rows.push_back('{CMD_REPLACE,    WORD_MAX,      WORD_MIN,  1, 0, ST_OK,        '0, 0});
    directed_rows.push_back('{CMD_RSVD_HI,    '1,            '1,        1, 1, ST_OK,        '0, 16});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      for (int k = 0; k < row.rep; k++) begin
        send_cmd(row.cmd, word_t'(row.val + k), row.nval, !row.typed);
        if (row.typed) expected_words.push_back('{row.st, row.data, row.cnt, 1'b1});
      end
    end

    // random part: swing between filling and draining so the full and empty
    // edges are hit over and over, with wrap-around of the front slot
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = ((n / 30) % 4 == 2);
      if (ring_fill >= DQR_DEPTH)      filling = 1'b0;
      else if (ring_fill == 0)         filling = 1'b1;
      else if ($urandom_range(0, 19) == 0) filling = !filling;
      cmd = choose_command(filling);
      v   = (cmd == CMD_REPLACE) ? pick_target() : pick_value();
      send_cmd(cmd, v, pick_value(), 1'b1);
    end

    @(negedge clk);
    in_bus.valid <= 1'b0;
    no_idle = 1'b0;

    // the watchdog covers a result that never shows up
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[deque_with_replace_unit] OK");
    end else begin
      $display("[deque_with_replace_unit] ERROR");
    end
    $finish;
  end

endmodule
